/* rtl/ods_pkg.sv */
`timescale 1ns / 1ps

package ods_pkg;

  localparam int MAX_OBJECTS_DEF = 32;
  localparam int COORD_W         = 16;
  localparam int TYPE_W          = 8;
  localparam int DIFF_W          = COORD_W + 1;   // exact coordinate difference
  localparam int SQ_W            = 2 * COORD_W;   // |diff| <= 65535, square fits 32 bits
  localparam int DIST_W          = SQ_W + 1;      // sum of two squares

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_SORT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [TYPE_W-1:0]  typ;
  } obj_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DIFF,
    CELL_SQUARE,
    CELL_SUM,
    CELL_SORT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;   // odd/even pairing of the transposition sort
  } cell_ctrl_t;

endpackage

/* rtl/ods_if.sv */
`timescale 1ns / 1ps

interface ods_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [ods_pkg::COORD_W-1:0]   x_coord;
  logic signed [ods_pkg::COORD_W-1:0]   y_coord;
  logic        [ods_pkg::TYPE_W-1:0]    obj_type;

  modport source (output valid, opcode, x_coord, y_coord, obj_type, input ready);
  modport sink   (input valid, opcode, x_coord, y_coord, obj_type, output ready);
endinterface

interface ods_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ods_pkg::COORD_W-1:0]   out_x;
  logic signed [ods_pkg::COORD_W-1:0]   out_y;
  logic        [ods_pkg::TYPE_W-1:0]    out_type;
  logic                                 valid_res;
  logic                                 last;

  modport source (output valid, out_x, out_y, out_type, valid_res, last, input ready);
  modport sink   (input valid, out_x, out_y, out_type, valid_res, last, output ready);
endinterface

/* rtl/object_depth_sorter.sv */
`timescale 1ns / 1ps

// Depth sorter for painter's-order drawing.
// in_bus: one transaction per request. opcode add appends an object (x, y,
//   type) to the table; once MAX_OBJECTS are held, adds are dropped. opcode
//   sort carries the viewer position; obj_type is ignored.
// out_bus: a sort returns every stored object, farthest first by squared
//   distance (equal distances keep table order), last set on the final one.
//   The reordered table is kept for later sorts. Empty table: a single
//   transaction with valid_res low, last high, all fields zero.
// Throughput: adds can be issued back to back.
// A sort of n objects keeps in_ready low until its last result is loaded
//   into the output register: per-cell distance math (difference, square,
//   sum), n phases of odd-even transposition across the cell row, then
//   emission, in which the row rotates one slot toward the head per result
//   and waits while a stalled receiver has not taken the output register.
// Reset clears the object count, the state and the output valid; table contents
//   are not cleared. A stalled receiver simply holds the row and the output
//   register; nothing is lost.
module object_depth_sorter #(
  parameter int MAX_OBJECTS = ods_pkg::MAX_OBJECTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ods_in_if.sink          in_bus,
  ods_out_if.source       out_bus
);

  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_OBJECTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_SUM,
    ST_SORT,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  state_t                               state_r;
  logic [CNT_W-1:0]                     count_r;
  logic [CNT_W-1:0]                     step_r;     // sort phase / emit index
  logic signed [ods_pkg::COORD_W-1:0]   view_x_r, view_y_r;

  logic                                 out_valid_r;
  ods_pkg::obj_t                        out_obj_r;
  logic                                 out_vres_r;
  logic                                 out_last_r;

  logic                                 accept;
  logic                                 out_free;
  logic                                 at_last;
  ods_pkg::cell_ctrl_t                  ctrl;
  ods_pkg::obj_t                        load_obj;

  ods_pkg::obj_t                        cell_obj  [MAX_OBJECTS];
  logic [ods_pkg::DIST_W-1:0]           cell_dist [MAX_OBJECTS];
  logic                                 cell_swap [MAX_OBJECTS];

  assign in_bus.ready = (state_r == ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign at_last      = (step_r == count_r - CNT_W'(1));

  assign load_obj.x   = in_bus.x_coord;
  assign load_obj.y   = in_bus.y_coord;
  assign load_obj.typ = in_bus.obj_type;

  // Row control
  always_comb begin
    ctrl.op    = ods_pkg::CELL_HOLD;
    ctrl.phase = step_r[0];
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_bus.opcode == ods_pkg::OP_ADD) && (count_r < MAX_C)) begin
          ctrl.op = ods_pkg::CELL_LOAD;
        end
      end
      ST_DIFF:   ctrl.op = ods_pkg::CELL_DIFF;
      ST_SQUARE: ctrl.op = ods_pkg::CELL_SQUARE;
      ST_SUM:    ctrl.op = ods_pkg::CELL_SUM;
      ST_SORT:   ctrl.op = ods_pkg::CELL_SORT;
      ST_EMIT: begin
        if (out_free) begin
          ctrl.op = ods_pkg::CELL_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  // Cell row; cell 0 is the head (farthest after sort)
  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
    ods_pkg::obj_t               l_obj, r_obj;
    logic [ods_pkg::DIST_W-1:0]  l_dist, r_dist;
    logic                        l_swap;

    if (i == 0) begin : g_head
      assign l_obj  = '0;
      assign l_dist = '0;
      assign l_swap = 1'b0;
    end else begin : g_mid
      assign l_obj  = cell_obj[i-1];
      assign l_dist = cell_dist[i-1];
      assign l_swap = cell_swap[i-1];
    end

    if (i == MAX_OBJECTS - 1) begin : g_tail
      assign r_obj  = cell_obj[0];
      assign r_dist = '0;
    end else begin : g_body
      assign r_obj  = cell_obj[i+1];
      assign r_dist = cell_dist[i+1];
    end

    ods_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .view_x     (view_x_r),
      .view_y     (view_y_r),
      .load_obj   (load_obj),
      .head_obj   (cell_obj[0]),
      .left_obj   (l_obj),
      .left_dist  (l_dist),
      .left_swap  (l_swap),
      .right_obj  (r_obj),
      .right_dist (r_dist),
      .obj_o      (cell_obj[i]),
      .dist_o     (cell_dist[i]),
      .swap_o     (cell_swap[i])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (accept) begin
            if (in_bus.opcode == ods_pkg::OP_ADD) begin
              if (count_r < MAX_C) begin
                count_r <= count_r + CNT_W'(1);
              end
            end else begin
              view_x_r <= in_bus.x_coord;
              view_y_r <= in_bus.y_coord;
              state_r  <= (count_r == '0) ? ST_EMPTY : ST_DIFF;
            end
          end
        end
        ST_DIFF:   state_r <= ST_SQUARE;
        ST_SQUARE: state_r <= ST_SUM;
        ST_SUM:    state_r <= ST_SORT;
        ST_SORT: begin
          if (at_last) begin
            step_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_obj_r   <= cell_obj[0];
            out_vres_r  <= 1'b1;
            out_last_r  <= at_last;
            if (at_last) begin
              state_r <= ST_IDLE;
            end else begin
              step_r <= step_r + CNT_W'(1);
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_obj_r   <= '0;
            out_vres_r  <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_x     = out_obj_r.x;
  assign out_bus.out_y     = out_obj_r.y;
  assign out_bus.out_type  = out_obj_r.typ;
  assign out_bus.valid_res = out_vres_r;
  assign out_bus.last      = out_last_r;

endmodule

/* rtl/ods_cell.sv */
`timescale 1ns / 1ps

// One table slot: holds an object, computes its squared distance to the
// viewer, and trades contents with its neighbors during sort and rotate.
module ods_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                                clk,
  input  ods_pkg::cell_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                    count,
  input  logic signed [ods_pkg::COORD_W-1:0]  view_x,
  input  logic signed [ods_pkg::COORD_W-1:0]  view_y,
  input  ods_pkg::obj_t                       load_obj,
  input  ods_pkg::obj_t                       head_obj,
  input  ods_pkg::obj_t                       left_obj,
  input  logic [ods_pkg::DIST_W-1:0]          left_dist,
  input  logic                                left_swap,
  input  ods_pkg::obj_t                       right_obj,
  input  logic [ods_pkg::DIST_W-1:0]          right_dist,
  output ods_pkg::obj_t                       obj_o,
  output logic [ods_pkg::DIST_W-1:0]          dist_o,
  output logic                                swap_o
);

  localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1   = CNT_W'(IDX + 1);
  localparam logic             IDX_PAR  = IDX_C[0];

  ods_pkg::obj_t                             obj_r, obj_nxt;
  logic [ods_pkg::DIST_W-1:0]                dist_r, dist_nxt;
  logic signed [ods_pkg::DIFF_W-1:0]         dx_r, dy_r;
  logic [ods_pkg::SQ_W-1:0]                  sqx_r, sqy_r;
  logic signed [2*ods_pkg::DIFF_W-1:0]       prod_x, prod_y;

  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;

  // Left member of an active pair: swap when the right one is strictly farther.
  assign swap_o = (ctrl.op == ods_pkg::CELL_SORT) && (ctrl.phase == IDX_PAR) &&
                  (IDX_P1 < count) && (dist_r < right_dist);

  always_comb begin
    obj_nxt  = obj_r;
    dist_nxt = dist_r;
    case (ctrl.op)
      ods_pkg::CELL_LOAD: begin
        if (count == IDX_C) begin
          obj_nxt = load_obj;
        end
      end
      ods_pkg::CELL_SUM: begin
        dist_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};
      end
      ods_pkg::CELL_SORT: begin
        if (swap_o) begin
          obj_nxt  = right_obj;
          dist_nxt = right_dist;
        end else if (left_swap) begin
          obj_nxt  = left_obj;
          dist_nxt = left_dist;
        end
      end
      ods_pkg::CELL_ROTATE: begin
        obj_nxt  = (IDX_P1 == count) ? head_obj : right_obj;
        dist_nxt = right_dist;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    obj_r  <= obj_nxt;
    dist_r <= dist_nxt;
    if (ctrl.op == ods_pkg::CELL_DIFF) begin
      dx_r <= ods_pkg::DIFF_W'(obj_r.x) - ods_pkg::DIFF_W'(view_x);
      dy_r <= ods_pkg::DIFF_W'(obj_r.y) - ods_pkg::DIFF_W'(view_y);
    end
    if (ctrl.op == ods_pkg::CELL_SQUARE) begin
      sqx_r <= prod_x[ods_pkg::SQ_W-1:0];
      sqy_r <= prod_y[ods_pkg::SQ_W-1:0];
    end
  end

  assign obj_o  = obj_r;
  assign dist_o = dist_r;

endmodule
